### rtl/gibs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gibs_pkg
// Shared constants and types for the greedy IoU box suppression unit.
// ----------------------------------------------------------------------------
package gibs_pkg;

	localparam int DIM_W   = 12;
	localparam int SCORE_W = 16;
	localparam int CLASS_W = 8;
	localparam int SCORE_LSB = CLASS_W;
	localparam int AREA_W  = 2 * DIM_W;
	localparam int THR_W   = 16;
	localparam int MDIM_W  = 13;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_IOU_THR  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODEL_W  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODEL_H  = 2'd2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	// Per-cycle control broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic pop;
		logic push;
		logic clr;
	} chain_ctl_t;

endpackage

### rtl/gibs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gibs_cell
// One slot of the candidate chain: sorted insertion, shift toward the head on
// a pop, and a tail write for boxes that survive a suppression pass.
// ----------------------------------------------------------------------------
module gibs_cell #(
	parameter int CAND_W = 80,
	parameter int IDX_W  = 8,
	parameter int INDEX  = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  gibs_pkg::chain_ctl_t        ctl,
	input  logic [IDX_W-1:0]            wr_pos,
	input  logic [gibs_pkg::SCORE_W-1:0] new_score,
	input  logic [CAND_W-1:0]           new_cand,
	input  logic [CAND_W-1:0]           left_cand,
	input  logic                        left_valid,
	input  logic                        left_gt,
	input  logic [CAND_W-1:0]           right_cand,
	input  logic                        right_valid,
	output logic [CAND_W-1:0]           cand,
	output logic                        valid,
	output logic                        gt
);
	import gibs_pkg::*;

	logic [CAND_W-1:0] cand_q;
	logic              valid_q;
	logic              wr_here;

	// Equal scores stay ahead of a new box, which keeps load order on ties.
	assign gt      = valid_q && (cand_q[SCORE_LSB +: SCORE_W] >= new_score);
	assign wr_here = ctl.push && (wr_pos == IDX_W'(INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clr) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			if (!gt) begin
				valid_q <= left_gt ? 1'b1 : left_valid;
			end
		end else if (wr_here) begin
			valid_q <= 1'b1;
		end else if (ctl.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (!gt) begin
				cand_q <= left_gt ? new_cand : left_cand;
			end
		end else if (wr_here) begin
			cand_q <= new_cand;
		end else if (ctl.pop) begin
			cand_q <= right_cand;
		end
	end

	assign cand  = cand_q;
	assign valid = valid_q;

endmodule

### rtl/gibs_iou.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gibs_iou
// Four-stage overlap test of a streamed candidate against the current kept
// box: intersection, areas, union, threshold product, then compare.
// ----------------------------------------------------------------------------
module gibs_iou #(
	parameter int COORD_BITS = 12,
	parameter int CAND_W     = 80
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [CAND_W-1:0]            ref_cand,
	input  logic [gibs_pkg::AREA_W-1:0]  ref_area,
	input  logic [gibs_pkg::THR_W-1:0]   thr,
	input  logic                         in_valid,
	input  logic [CAND_W-1:0]            in_cand,
	output logic                         res_valid,
	output logic [CAND_W-1:0]            res_cand,
	output logic                         suppress,
	output logic                         busy
);
	import gibs_pkg::*;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [DIM_W-1:0]             w;
		logic [DIM_W-1:0]             h;
		logic [SCORE_W-1:0]           score;
		logic [CLASS_W-1:0]           cls;
	} cand_t;

	localparam int EW     = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;
	localparam int UNI_W  = AREA_W + 1;
	localparam int PROD_W = THR_W + UNI_W;

	cand_t a, b, c_s1;
	logic signed [EW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
	logic signed [EW-1:0] ix, iy;

	logic [CAND_W-1:0] cand_s1, cand_s2, cand_s3, cand_s4;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [DIM_W-1:0]  ix_s1, iy_s1;
	logic [AREA_W-1:0] inter_s2, areab_s2, inter_s3, inter_s4;
	logic [UNI_W-1:0]  uni_s3;
	logic [PROD_W-1:0] prod_s4;

	assign a    = cand_t'(ref_cand);
	assign b    = cand_t'(in_cand);
	assign c_s1 = cand_t'(cand_s1);

	always_comb begin
		ax0 = EW'(a.x);
		ay0 = EW'(a.y);
		bx0 = EW'(b.x);
		by0 = EW'(b.y);
		ax1 = ax0 + $signed({{(EW-DIM_W){1'b0}}, a.w});
		ay1 = ay0 + $signed({{(EW-DIM_W){1'b0}}, a.h});
		bx1 = bx0 + $signed({{(EW-DIM_W){1'b0}}, b.w});
		by1 = by0 + $signed({{(EW-DIM_W){1'b0}}, b.h});
		ix  = ((ax1 < bx1) ? ax1 : bx1) - ((ax0 > bx0) ? ax0 : bx0);
		iy  = ((ay1 < by1) ? ay1 : by1) - ((ay0 > by0) ? ay0 : by0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// The overlap never exceeds the smaller side, so twelve bits hold it.
	always_ff @(posedge clk) begin
		cand_s1  <= in_cand;
		ix_s1    <= (ix < 0) ? '0 : ix[DIM_W-1:0];
		iy_s1    <= (iy < 0) ? '0 : iy[DIM_W-1:0];
		cand_s2  <= cand_s1;
		inter_s2 <= ix_s1 * iy_s1;
		areab_s2 <= c_s1.w * c_s1.h;
		cand_s3  <= cand_s2;
		inter_s3 <= inter_s2;
		uni_s3   <= UNI_W'(ref_area) + UNI_W'(areab_s2) - UNI_W'(inter_s2);
		cand_s4  <= cand_s3;
		inter_s4 <= inter_s3;
		prod_s4  <= thr * uni_s3;
	end

	assign res_valid = v_s4;
	assign res_cand  = cand_s4;
	assign suppress  = PROD_W'({inter_s4, 16'h0000}) > prod_s4;
	assign busy      = v_s1 | v_s2 | v_s3 | v_s4;

endmodule

### rtl/greedy_iou_box_suppression_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_iou_box_suppression_unit
// Greedy non-maximum suppression over a sorted chain of candidate cells.
// ----------------------------------------------------------------------------
// A load transfer inserts the box at its place in descending score order, so
// the chain is always sorted. A run transfer is accepted only while the
// output is free, and further input transfers are stalled until the run
// ends. Each kept box is taken off the head of the chain; the remaining
// candidates then stream through the four-stage overlap unit, and the
// pipeline drains before the next box is chosen. Suppressed boxes leave
// the chain as they pass.
module greedy_iou_box_suppression_unit #(
	parameter int MAX_CAND   = 256,
	parameter int MAX_KEPT   = 64,
	parameter int COORD_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gibs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gibs_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [COORD_BITS-1:0]        box_x,
	input  logic signed [COORD_BITS-1:0]        box_y,
	input  logic [gibs_pkg::DIM_W-1:0]          box_w,
	input  logic [gibs_pkg::DIM_W-1:0]          box_h,
	input  logic [gibs_pkg::SCORE_W-1:0]        score,
	input  logic [gibs_pkg::CLASS_W-1:0]        class_id,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                valid_res,
	output logic [12:0]                         kept_x,
	output logic [12:0]                         kept_y,
	output logic signed [13:0]                  kept_w,
	output logic signed [13:0]                  kept_h,
	output logic [gibs_pkg::SCORE_W-1:0]        kept_score,
	output logic [gibs_pkg::CLASS_W-1:0]        kept_class,
	output logic                                last,
	output logic                                overflow
);
	import gibs_pkg::*;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
		logic [DIM_W-1:0]             w;
		logic [DIM_W-1:0]             h;
		logic [SCORE_W-1:0]           score;
		logic [CLASS_W-1:0]           cls;
	} cand_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_KEEP = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	localparam int CAND_W = $bits(cand_t);
	localparam int IDX_W  = $clog2(MAX_CAND);
	localparam int CNT_W  = $clog2(MAX_CAND + 1);
	localparam int KW     = $clog2(MAX_KEPT + 1);
	localparam int CW     = 18;

	state_t state_q;
	logic [THR_W-1:0]  thr_q;
	logic [MDIM_W-1:0] mw_q, mh_q;
	logic [CNT_W-1:0]  cnt_q, pop_left_q;
	logic [KW-1:0]     kept_cnt_q;
	logic              dropped_q;
	cand_t             r_q;
	logic [AREA_W-1:0] area_q;

	logic [CAND_W-1:0] cand_w [MAX_CAND];
	logic              valid_w [MAX_CAND];
	logic              gt_w [MAX_CAND];

	chain_ctl_t ctl;
	cand_t      in_pack, head;
	logic       in_acc, load_acc, run_acc, full, out_free;
	logic       done_cond, keep_go, scan_pop, done_go;
	logic       emit_empty, emit_kept, emit;
	logic       iou_valid, iou_sup, iou_busy;
	logic [CAND_W-1:0] iou_cand, new_cand;
	logic [IDX_W-1:0]  wr_pos;
	logic [CNT_W-1:0]  cnt_popped;

	// Clamped result fields of the kept box.
	logic signed [CW-1:0] rx, ry, mw_s, mh_s, dw, dh, kx, ky, kw, kh, rw, rh;

	assign in_pack = '{x: box_x, y: box_y, w: box_w, h: box_h, score: score, cls: class_id};
	assign head    = cand_t'(cand_w[0]);

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || (cmd == CMD_RUN && !out_free);
	assign in_acc   = in_valid && !in_stall;
	assign load_acc = in_acc && (cmd == CMD_LOAD);
	assign run_acc  = in_acc && (cmd == CMD_RUN);
	assign full     = (cnt_q == CNT_W'(MAX_CAND));

	assign done_cond = (cnt_q == '0) || (kept_cnt_q == KW'(MAX_KEPT));
	assign keep_go   = (state_q == ST_KEEP) && !done_cond
	                   && ((kept_cnt_q == '0) || out_free);
	assign scan_pop  = (state_q == ST_SCAN) && (pop_left_q != '0);
	assign done_go   = (state_q == ST_DONE) && out_free;

	assign emit_empty = run_acc && (cnt_q == '0);
	assign emit_kept  = keep_go && (kept_cnt_q != '0);
	assign emit       = emit_empty || emit_kept || done_go;

	assign ctl.ins  = load_acc && !full;
	assign ctl.pop  = keep_go || scan_pop;
	assign ctl.push = iou_valid && !iou_sup;
	assign ctl.clr  = done_go;

	assign cnt_popped = cnt_q - CNT_W'(ctl.pop);
	assign wr_pos     = cnt_popped[IDX_W-1:0];
	assign new_cand   = ctl.ins ? CAND_W'(in_pack) : iou_cand;

	for (genvar i = 0; i < MAX_CAND; i++) begin : g_chain
		gibs_cell #(
			.CAND_W (CAND_W),
			.IDX_W  (IDX_W),
			.INDEX  (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.wr_pos      (wr_pos),
			.new_score   (score),
			.new_cand    (new_cand),
			.left_cand   ((i == 0) ? '0 : cand_w[(i == 0) ? 0 : i-1]),
			.left_valid  ((i == 0) ? 1'b0 : valid_w[(i == 0) ? 0 : i-1]),
			.left_gt     ((i == 0) ? 1'b1 : gt_w[(i == 0) ? 0 : i-1]),
			.right_cand  ((i == MAX_CAND-1) ? '0 : cand_w[(i == MAX_CAND-1) ? i : i+1]),
			.right_valid ((i == MAX_CAND-1) ? 1'b0 : valid_w[(i == MAX_CAND-1) ? i : i+1]),
			.cand        (cand_w[i]),
			.valid       (valid_w[i]),
			.gt          (gt_w[i])
		);
	end

	gibs_iou #(
		.COORD_BITS (COORD_BITS),
		.CAND_W     (CAND_W)
	) u_iou (
		.clk       (clk),
		.arst_n    (arst_n),
		.ref_cand  (CAND_W'(r_q)),
		.ref_area  (area_q),
		.thr       (thr_q),
		.in_valid  (scan_pop),
		.in_cand   (cand_w[0]),
		.res_valid (iou_valid),
		.res_cand  (iou_cand),
		.suppress  (iou_sup),
		.busy      (iou_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_W'(29491);
			mw_q  <= MDIM_W'(640);
			mh_q  <= MDIM_W'(640);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IOU_THR: thr_q <= cfg_data[THR_W-1:0];
				REG_MODEL_W: mw_q  <= cfg_data[MDIM_W-1:0];
				REG_MODEL_H: mh_q  <= cfg_data[MDIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			pop_left_q <= '0;
			kept_cnt_q <= '0;
			dropped_q  <= 1'b0;
		end else begin
			if (ctl.ins) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (ctl.clr) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_popped + CNT_W'(ctl.push);
			end
			if (load_acc && full) begin
				dropped_q <= 1'b1;
			end else if (emit_empty || done_go) begin
				dropped_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (run_acc && cnt_q != '0) begin
						state_q    <= ST_KEEP;
						kept_cnt_q <= '0;
					end
				end
				ST_KEEP: begin
					if (done_cond) begin
						state_q <= ST_DONE;
					end else if (keep_go) begin
						state_q    <= ST_SCAN;
						kept_cnt_q <= kept_cnt_q + 1'b1;
						pop_left_q <= cnt_q - 1'b1;
					end
				end
				ST_SCAN: begin
					if (scan_pop) begin
						pop_left_q <= pop_left_q - 1'b1;
					end else if (!iou_busy) begin
						state_q <= ST_KEEP;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The kept box waits here until the next keep or the end of the run
	// tells whether it is the last one.
	always_ff @(posedge clk) begin
		if (keep_go) begin
			r_q    <= head;
			area_q <= head.w * head.h;
		end
	end

	always_comb begin
		rx   = CW'(r_q.x);
		ry   = CW'(r_q.y);
		rw   = $signed({{(CW-DIM_W){1'b0}}, r_q.w});
		rh   = $signed({{(CW-DIM_W){1'b0}}, r_q.h});
		mw_s = $signed({{(CW-MDIM_W){1'b0}}, mw_q});
		mh_s = $signed({{(CW-MDIM_W){1'b0}}, mh_q});
		kx   = (rx < 0) ? '0 : ((rx > mw_s) ? mw_s : rx);
		ky   = (ry < 0) ? '0 : ((ry > mh_s) ? mh_s : ry);
		dw   = mw_s - rx;
		dh   = mh_s - ry;
		kw   = (rw < dw) ? rw : dw;
		kh   = (rh < dh) ? rh : dh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			overflow <= dropped_q;
			if (emit_empty) begin
				valid_res  <= 1'b0;
				kept_x     <= '0;
				kept_y     <= '0;
				kept_w     <= '0;
				kept_h     <= '0;
				kept_score <= '0;
				kept_class <= '0;
				last       <= 1'b1;
			end else begin
				valid_res  <= 1'b1;
				kept_x     <= kx[12:0];
				kept_y     <= ky[12:0];
				kept_w     <= kw[13:0];
				kept_h     <= kh[13:0];
				kept_score <= r_q.score;
				kept_class <= r_q.cls;
				last       <= done_go;
			end
		end
	end

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		kept_cnt_q <= KW'(MAX_KEPT))
		else $error("kept count passed its limit");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_CAND))
		else $error("stored count passed capacity");

	a_keep_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_KEEP) |-> !iou_busy)
		else $error("overlap pipeline still busy when choosing next box");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && out_valid) |-> !out_stall)
		else $error("result overwritten while stalled");

	a_push_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (state_q == ST_SCAN))
		else $error("surviving box written outside a scan pass");

endmodule

### tb/sv/gibs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gibs_checker
// Watches the configuration port and both channels of the suppression unit.
// It keeps its own copy of the candidate store and the registers. On each run
// transfer it works out the kept boxes and compares every output transfer
// against the oldest expected box, field by field.
// ----------------------------------------------------------------------------
module gibs_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [gibs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gibs_pkg::CFG_W-1:0]          cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic                                cmd,
	input  logic signed [11:0]                  box_x,
	input  logic signed [11:0]                  box_y,
	input  logic [gibs_pkg::DIM_W-1:0]          box_w,
	input  logic [gibs_pkg::DIM_W-1:0]          box_h,
	input  logic [gibs_pkg::SCORE_W-1:0]        score,
	input  logic [gibs_pkg::CLASS_W-1:0]        class_id,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic                                valid_res,
	input  logic [12:0]                         kept_x,
	input  logic [12:0]                         kept_y,
	input  logic signed [13:0]                  kept_w,
	input  logic signed [13:0]                  kept_h,
	input  logic [gibs_pkg::SCORE_W-1:0]        kept_score,
	input  logic [gibs_pkg::CLASS_W-1:0]        kept_class,
	input  logic                                last,
	input  logic                                overflow,
	output int                                  mismatches,
	output int                                  pending
);
	import gibs_pkg::*;

	localparam int STORE_DEPTH = 256;
	localparam int KEEP_LIMIT  = 64;

	typedef struct {
		int x;
		int y;
		int w;
		int h;
		int s;
		int c;
	} cand_t;

	typedef struct packed {
		logic               vld;
		logic [12:0]        x;
		logic [12:0]        y;
		logic [13:0]        w;
		logic [13:0]        h;
		logic [SCORE_W-1:0] s;
		logic [CLASS_W-1:0] c;
		logic               lst;
		logic               ovf;
	} kept_box_t;

	cand_t      cand_store[STORE_DEPTH];
	int         cand_count;
	bit         dropped;
	int         iou_thr;
	int         mdl_w;
	int         mdl_h;
	kept_box_t  kept_box_q[$];

	assign pending = kept_box_q.size();

	function automatic bit too_close(cand_t a, cand_t b);
		int ix;
		int iy;
		longint inter;
		longint uni;
		ix = ((a.x + a.w < b.x + b.w) ? a.x + a.w : b.x + b.w) - ((a.x > b.x) ? a.x : b.x);
		iy = ((a.y + a.h < b.y + b.h) ? a.y + a.h : b.y + b.h) - ((a.y > b.y) ? a.y : b.y);
		if (ix < 0) ix = 0;
		if (iy < 0) iy = 0;
		inter = longint'(ix) * longint'(iy);
		uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
		return (inter << 16) > longint'(iou_thr) * uni;
	endfunction

	task automatic run_suppression();
		int order[STORE_DEPTH];
		bit gone[STORE_DEPTH];
		int i;
		int j;
		int idx;
		int kept;
		int kx;
		int ky;
		int kw;
		int kh;
		cand_t d;
		kept_box_t e;
		kept = 0;
		if (cand_count == 0) begin
			e = '0;
			e.lst = 1'b1;
			e.ovf = dropped;
			kept_box_q.insert(kept_box_q.size(), e);
			dropped = 0;
			return;
		end
		// Stable insertion sort, highest score first.
		for (i = 0; i < cand_count; i++) begin
			j = i;
			while (j > 0 && cand_store[order[j-1]].s < cand_store[i].s) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
			gone[i] = 0;
		end
		for (i = 0; i < cand_count && kept < KEEP_LIMIT; i++) begin
			if (!gone[i]) begin
				d = cand_store[order[i]];
				kx = (d.x < mdl_w) ? d.x : mdl_w;
				if (kx < 0) kx = 0;
				ky = (d.y < mdl_h) ? d.y : mdl_h;
				if (ky < 0) ky = 0;
				kw = (d.w < mdl_w - d.x) ? d.w : mdl_w - d.x;
				kh = (d.h < mdl_h - d.y) ? d.h : mdl_h - d.y;
				e.vld = 1'b1;
				e.x = kx[12:0];
				e.y = ky[12:0];
				e.w = kw[13:0];
				e.h = kh[13:0];
				e.s = d.s[SCORE_W-1:0];
				e.c = d.c[CLASS_W-1:0];
				e.lst = 1'b0;
				e.ovf = dropped;
				kept_box_q.insert(kept_box_q.size(), e);
				kept++;
				for (j = i + 1; j < cand_count; j++) begin
					idx = order[j];
					if (!gone[j] && too_close(d, cand_store[idx])) gone[j] = 1;
				end
			end
		end
		kept_box_q[kept_box_q.size() - 1].lst = 1'b1;
		cand_count = 0;
		dropped = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		kept_box_t e;
		kept_box_t got;
		if (!arst_n) begin
			cand_count = 0;
			dropped = 0;
			iou_thr = 29491;
			mdl_w = 640;
			mdl_h = 640;
			mismatches = 0;
			kept_box_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_IOU_THR: iou_thr = cfg_data;
					REG_MODEL_W: mdl_w = cfg_data & 16'h1FFF;
					REG_MODEL_H: mdl_h = cfg_data & 16'h1FFF;
					default: ;
				endcase
			end
			// Check the output first: a result never comes in the cycle of its run.
			if (out_valid && !out_stall) begin
				got = {valid_res, kept_x, kept_y, kept_w, kept_h, kept_score, kept_class,
					last, overflow};
				if (kept_box_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result transfer %p", $time, got);
				end else begin
					e = kept_box_q.pop_front();
					if (got.vld !== e.vld || got.x !== e.x || got.y !== e.y || got.w !== e.w
						|| got.h !== e.h || got.s !== e.s || got.c !== e.c
						|| got.lst !== e.lst || got.ovf !== e.ovf) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: result mismatch expected %p actual %p", $time, e, got);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (cmd == CMD_LOAD) begin
					if (cand_count < STORE_DEPTH) begin
						cand_store[cand_count] = '{int'(box_x), int'(box_y), int'(box_w),
							int'(box_h), int'(score), int'(class_id)};
						cand_count++;
					end else begin
						dropped = 1;
					end
				end else begin
					run_suppression();
				end
			end
		end
	end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the greedy IoU box suppression unit.
// ----------------------------------------------------------------------------
// Directed batches cover coordinate and size extremes, equal scores, heavy
// overlap, zero-size boxes, empty runs and a full store. Random batches are
// mostly clustered boxes so that suppression really happens, under changing
// thresholds and model sizes. Both channels idle at random.
module testbench;
	import gibs_pkg::*;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int ITEM_GOAL   = 420;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  cmd;
	logic signed [11:0]    box_x;
	logic signed [11:0]    box_y;
	logic [DIM_W-1:0]      box_w;
	logic [DIM_W-1:0]      box_h;
	logic [SCORE_W-1:0]    score;
	logic [CLASS_W-1:0]    class_id;
	logic                  out_valid;
	logic                  out_stall;
	logic                  valid_res;
	logic [12:0]           kept_x;
	logic [12:0]           kept_y;
	logic signed [13:0]    kept_w;
	logic signed [13:0]    kept_h;
	logic [SCORE_W-1:0]    kept_score;
	logic [CLASS_W-1:0]    kept_class;
	logic                  last;
	logic                  overflow;
	int                    mismatches;
	int                    pending;
	int                    cycles = 0;
	int                    items_sent;
	bit                    sender_busy_mode;
	bit                    hold_go;

	greedy_iou_box_suppression_unit DUT (.*);

	gibs_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off on request.
	initial begin
		int hold_left;
		int r;
		bit hold_used;
		out_stall = 0;
		hold_left = 0;
		hold_used = 0;
		forever begin
			@(posedge clk);
			if (hold_go && !hold_used) begin
				hold_left = 600;
				hold_used = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (sender_busy_mode) out_stall <= 1'b0;
				else if (r < 65) out_stall <= 1'b0;
				else if (r < 95) out_stall <= 1'b1;
				else out_stall <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	task automatic sender_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		n = 0;
		if (!sender_busy_mode) begin
			if (r < 25) n = $urandom_range(1, 3);
			else if (r < 30) n = $urandom_range(10, 40);
		end
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_item(logic c, int x, int y, int w, int h, int s, int k);
		sender_gap();
		in_valid <= 1'b1;
		cmd <= c;
		box_x <= x[11:0];
		box_y <= y[11:0];
		box_w <= w[11:0];
		box_h <= h[11:0];
		score <= s[15:0];
		class_id <= k[7:0];
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic load_box(int x, int y, int w, int h, int s, int k);
		send_item(CMD_LOAD, x, y, w, h, s, k);
	endtask

	task automatic start_run();
		send_item(CMD_RUN, $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
			$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 65535),
			$urandom_range(0, 255));
	endtask

	// Waits for every expected result, then lets the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int v);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v[15:0];
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_config();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) write_reg(REG_IOU_THR, 0);
		else if (r == 1) write_reg(REG_IOU_THR, 65535);
		else write_reg(REG_IOU_THR, $urandom_range(6000, 60000));
		r = $urandom_range(0, 9);
		if (r == 0) write_reg(REG_MODEL_W, 1);
		else if (r == 1) write_reg(REG_MODEL_W, 4096);
		else write_reg(REG_MODEL_W, $urandom_range(100, 1500));
		r = $urandom_range(0, 9);
		if (r == 0) write_reg(REG_MODEL_H, 1);
		else if (r == 1) write_reg(REG_MODEL_H, 4096);
		else write_reg(REG_MODEL_H, $urandom_range(100, 1500));
	endtask

	task automatic random_batch(int n);
		int i;
		int cx;
		int cy;
		int base_s;
		cx = $urandom_range(0, 1200) - 200;
		cy = $urandom_range(0, 1200) - 200;
		base_s = $urandom_range(0, 65535);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7)
				load_box(cx + $urandom_range(0, 40) - 20, cy + $urandom_range(0, 40) - 20,
					$urandom_range(20, 120), $urandom_range(20, 120),
					($urandom_range(0, 3) == 0) ? base_s : $urandom_range(0, 65535),
					$urandom_range(0, 255));
			else
				load_box($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
					$urandom_range(1, 4095), $urandom_range(1, 4095),
					$urandom_range(0, 65535), $urandom_range(0, 255));
		end
		start_run();
	endtask

	initial begin
		int i;
		int n;
		arst_n = 0;
		cfg_wr_en = 0;
		cfg_index = REG_IOU_THR;
		cfg_data = 0;
		in_valid = 0;
		cmd = CMD_LOAD;
		box_x = 0;
		box_y = 0;
		box_w = 0;
		box_h = 0;
		score = 0;
		class_id = 0;
		items_sent = 0;
		sender_busy_mode = 0;
		hold_go = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty run first, then extremes, ties, overlap and zero-size boxes.
		start_run();
		load_box(-2048, 2047, 4095, 4095, 65535, 255);
		load_box(2047, -2048, 1, 1, 0, 0);
		load_box(10, 10, 100, 100, 40000, 3);
		load_box(12, 11, 100, 100, 40000, 4);
		load_box(300, 300, 50, 50, 40000, 5);
		load_box(600, 600, 100, 100, 1234, 6);
		load_box(50, 50, 0, 30, 50000, 7);
		load_box(50, 50, 30, 0, 50000, 8);
		load_box(-5, -5, 20, 20, 65535, 9);
		start_run();
		wait_idle();
		write_reg(REG_IOU_THR, 0);
		write_reg(REG_MODEL_W, 1);
		write_reg(REG_MODEL_H, 4096);
		load_box(0, 0, 10, 10, 100, 1);
		load_box(500, 500, 10, 10, 200, 2);
		load_box(-100, 4000 - 4096, 4095, 2, 300, 3);
		start_run();
		wait_idle();
		write_reg(REG_IOU_THR, 65535);
		write_reg(REG_MODEL_W, 4096);
		write_reg(REG_MODEL_H, 1);
		load_box(0, 0, 10, 10, 100, 1);
		load_box(0, 0, 10, 10, 100, 2);
		load_box(2047, 2047, 4095, 4095, 65535, 255);
		start_run();
		wait_idle();

		// Fill the store past capacity, with ties, so loads get dropped.
		write_reg(REG_IOU_THR, 29491);
		write_reg(REG_MODEL_W, 640);
		write_reg(REG_MODEL_H, 640);
		sender_busy_mode = 1;
		for (i = 0; i < 260; i++)
			load_box((i % 16) * 40, (i / 16) * 40, 30 + (i % 7), 30 + (i % 5),
				$urandom_range(0, 15) * 4096, i);
		start_run();
		sender_busy_mode = 0;
		start_run();
		wait_idle();

		// Random batches; the receiver holds off once, which stalls the sender.
		hold_go = 1;
		while (items_sent < ITEM_GOAL) begin
			if ($urandom_range(0, 4) == 0) begin
				wait_idle();
				random_config();
			end
			sender_busy_mode = ($urandom_range(0, 5) == 0);
			if ($urandom_range(0, 9) == 0) n = 0;
			else if ($urandom_range(0, 9) == 0) n = $urandom_range(13, 60);
			else n = $urandom_range(1, 12);
			random_batch(n);
		end
		sender_busy_mode = 0;
		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
